>>> sv/sync_length_frame_extractor_defines.svh
// Assertion macros for the sync length frame extractor.
`ifndef SYNC_LENGTH_FRAME_EXTRACTOR_DEFINES_SVH
`define SYNC_LENGTH_FRAME_EXTRACTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define SLFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SLFE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLFE_ASSERT(lbl, prop, msg)
`define SLFE_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> sv/slfe_pkg.sv
// Shared types and constants of the sync length frame extractor.
`timescale 1ns / 1ps

package slfe_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned REG_IDX_W = 2;
  localparam int unsigned HDR_N     = 5;
  localparam int unsigned CNT_W     = $clog2(HDR_N + 1);

  localparam logic [REG_IDX_W-1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TAG_FIRST   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_TAG_SECOND  = 2'd3;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hF1;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hDD;
  localparam logic [BYTE_W-1:0] TAG_FIRST_RST   = 8'h01;
  localparam logic [BYTE_W-1:0] TAG_SECOND_RST  = 8'h02;
  localparam logic [BYTE_W-1:0] MIN_LEN         = 8'd4;

  typedef enum logic [7:0] {
    PH_HUNT1   = 8'b0000_0001,
    PH_HUNT2   = 8'b0000_0010,
    PH_LEN     = 8'b0000_0100,
    PH_ADDRLO  = 8'b0000_1000,
    PH_ADDRHI  = 8'b0001_0000,
    PH_SKIP1   = 8'b0010_0000,
    PH_SKIP2   = 8'b0100_0000,
    PH_PAYLOAD = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic                          one;
    logic                          five;
    logic [HDR_N-1:0][BYTE_W-1:0]  data;
    logic [HDR_N-1:0]              last;
  } push_t;

endpackage

>>> sv/slfe_parser.sv
// Frame parser: sync hunt, header capture and result generation per item.
`timescale 1ns / 1ps

module slfe_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wen,
  input  logic [slfe_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [slfe_pkg::BYTE_W-1:0]         cfg_wdata,
  input  logic                                accept,
  input  logic [slfe_pkg::BYTE_W-1:0]         in_byte,
  output logic                                need_five,
  output slfe_pkg::push_t                     push
);

  logic [slfe_pkg::BYTE_W-1:0] sync_first_r, sync_second_r, tag_first_r, tag_second_r;
  slfe_pkg::phase_t            phase_r, phase_nxt;
  logic [slfe_pkg::BYTE_W-1:0] len_r, len_nxt;
  logic [slfe_pkg::BYTE_W-1:0] addr_lo_r, addr_lo_nxt;
  logic [slfe_pkg::BYTE_W-1:0] addr_hi_r, addr_hi_nxt;
  logic [slfe_pkg::BYTE_W-1:0] left_r, left_nxt;
  logic [slfe_pkg::BYTE_W-1:0] plen;

  assign need_five = (phase_r == slfe_pkg::PH_SKIP2);
  assign plen      = len_r - slfe_pkg::MIN_LEN;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= slfe_pkg::SYNC_FIRST_RST;
      sync_second_r <= slfe_pkg::SYNC_SECOND_RST;
      tag_first_r   <= slfe_pkg::TAG_FIRST_RST;
      tag_second_r  <= slfe_pkg::TAG_SECOND_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        slfe_pkg::REG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
        slfe_pkg::REG_SYNC_SECOND: sync_second_r <= cfg_wdata;
        slfe_pkg::REG_TAG_FIRST:   tag_first_r   <= cfg_wdata;
        slfe_pkg::REG_TAG_SECOND:  tag_second_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    len_nxt     = len_r;
    addr_lo_nxt = addr_lo_r;
    addr_hi_nxt = addr_hi_r;
    left_nxt    = left_r;
    push        = '0;
    if (accept) begin
      unique case (phase_r)
        slfe_pkg::PH_HUNT1: begin
          if (in_byte == sync_first_r) phase_nxt = slfe_pkg::PH_HUNT2;
        end
        slfe_pkg::PH_HUNT2: begin
          priority if (in_byte == sync_second_r) phase_nxt = slfe_pkg::PH_LEN;
          else if (in_byte == sync_first_r) phase_nxt = slfe_pkg::PH_HUNT2;
          else phase_nxt = slfe_pkg::PH_HUNT1;
        end
        slfe_pkg::PH_LEN: begin
          len_nxt   = in_byte;
          phase_nxt = (in_byte < slfe_pkg::MIN_LEN) ? slfe_pkg::PH_HUNT1
                                                    : slfe_pkg::PH_ADDRLO;
        end
        slfe_pkg::PH_ADDRLO: begin
          addr_lo_nxt = in_byte;
          phase_nxt   = slfe_pkg::PH_ADDRHI;
        end
        slfe_pkg::PH_ADDRHI: begin
          addr_hi_nxt = in_byte;
          phase_nxt   = slfe_pkg::PH_SKIP1;
        end
        slfe_pkg::PH_SKIP1: begin
          phase_nxt = slfe_pkg::PH_SKIP2;
        end
        slfe_pkg::PH_SKIP2: begin
          push.five    = 1'b1;
          push.data[0] = tag_first_r;
          push.data[1] = tag_second_r;
          push.data[2] = plen;
          push.data[3] = addr_lo_r;
          push.data[4] = addr_hi_r;
          push.last[4] = (plen == '0);
          left_nxt     = plen;
          phase_nxt    = (plen == '0) ? slfe_pkg::PH_HUNT1 : slfe_pkg::PH_PAYLOAD;
        end
        slfe_pkg::PH_PAYLOAD: begin
          push.one     = 1'b1;
          push.data[0] = in_byte;
          push.last[0] = (left_r == 8'd1);
          left_nxt     = left_r - 8'd1;
          if (left_r == 8'd1) phase_nxt = slfe_pkg::PH_HUNT1;
        end
        default: phase_nxt = slfe_pkg::PH_HUNT1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= slfe_pkg::PH_HUNT1;
      len_r     <= '0;
      addr_lo_r <= '0;
      addr_hi_r <= '0;
      left_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      len_r     <= len_nxt;
      addr_lo_r <= addr_lo_nxt;
      addr_hi_r <= addr_hi_nxt;
      left_r    <= left_nxt;
    end
  end

endmodule

>>> sv/slfe_outq.sv
// Five-entry result queue: loads one or five, drains one per cycle while ready.
`timescale 1ns / 1ps
`include "sync_length_frame_extractor_defines.svh"

module slfe_outq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  slfe_pkg::push_t              push,
  output logic                         empty,
  output logic                         full,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [slfe_pkg::BYTE_W-1:0]  out_tdata,
  output logic                         out_tlast
);

  logic [slfe_pkg::BYTE_W-1:0] data_r [slfe_pkg::HDR_N];
  logic [slfe_pkg::BYTE_W-1:0] data_nxt [slfe_pkg::HDR_N];
  logic [slfe_pkg::HDR_N-1:0]  last_r, last_nxt;
  logic [slfe_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [slfe_pkg::CNT_W-1:0]  wr_idx;
  logic                        pop;

  assign empty      = (count_r == '0);
  assign full       = (count_r == slfe_pkg::CNT_W'(slfe_pkg::HDR_N));
  assign out_tvalid = !empty;
  assign out_tdata  = data_r[0];
  assign out_tlast  = last_r[0];
  assign pop        = out_tvalid && out_tready;
  assign wr_idx     = count_r - slfe_pkg::CNT_W'(pop);

  always_comb begin
    for (int i = 0; i < slfe_pkg::HDR_N; i++) begin
      if (pop && (i < slfe_pkg::HDR_N - 1)) begin
        data_nxt[i] = data_r[i+1];
        last_nxt[i] = last_r[i+1];
      end else begin
        data_nxt[i] = data_r[i];
        last_nxt[i] = last_r[i];
      end
      if (push.five) begin
        data_nxt[i] = push.data[i];
        last_nxt[i] = push.last[i];
      end else if (push.one && (wr_idx == slfe_pkg::CNT_W'(i))) begin
        data_nxt[i] = push.data[0];
        last_nxt[i] = push.last[0];
      end
    end
    count_nxt = count_r - slfe_pkg::CNT_W'(pop) + slfe_pkg::CNT_W'(push.one)
              + (push.five ? slfe_pkg::CNT_W'(slfe_pkg::HDR_N) : '0);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < slfe_pkg::HDR_N; i++) begin
      data_r[i] <= data_nxt[i];
    end
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  `SLFE_ASSERT(a_count_bound, count_r <= slfe_pkg::CNT_W'(slfe_pkg::HDR_N), "count overflow")
  `SLFE_ASSERT(a_five_on_empty, push.five |-> empty, "header load into busy queue")
  `SLFE_ASSERT(a_one_not_full, push.one |-> !full, "payload push into full queue")
  `SLFE_ASSERT(a_push_excl, !(push.one && push.five), "both push kinds at once")
  `SLFE_ASSERT_RST(a_reset_empty, !rst_n |=> empty, "queue not empty after reset")

endmodule

>>> sv/sync_length_frame_extractor.sv
// Top level of the sync length frame extractor.
//
// in_* : received bytes, one item per handshake (in_tdata holds in_byte).
// out_*: extracted frame bytes: tag_first, tag_second, L-4, address low,
//   address high, then L-4 payload bytes; out_tlast marks the final byte.
// cfg_*: register write port (sync_first, sync_second, tag_first,
//   tag_second); the user must write it only while the block is idle;
// the block does not enforce this. Each input byte is parsed in the
// cycle it is accepted and its results enter a five-entry result queue;
// the first result is visible the next cycle. Header and payload bytes
// stream at one item per cycle while the queue is not full. The second
// ignored byte yields five results, so that byte is accepted only once
// the queue is empty; the queue depth sets this. Hunt bytes and the
// other header bytes give no result and are taken in every cycle in
// which the queue is not full. Reset restores register defaults, empties
// the queue and restarts the sync hunt. When the receiver stalls the
// queue holds its items and the input backs up once the queue is full.
`timescale 1ns / 1ps

module sync_length_frame_extractor (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] in_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata,  // [7:0] out_byte
  output logic                                out_tlast,
  input  logic                                cfg_wen,
  input  logic [slfe_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                          cfg_wdata
);

  slfe_pkg::push_t push;
  logic            need_five;
  logic            q_empty;
  logic            q_full;
  logic            accept;

  assign in_tready = need_five ? q_empty : !q_full;
  assign accept    = in_tvalid && in_tready;

  slfe_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_byte   (in_tdata),
    .need_five (need_five),
    .push      (push)
  );

  slfe_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .empty      (q_empty),
    .full       (q_full),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
